FILE: sv/nal2ab_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the NAL to Annex B converter.
// Depends on nothing.
package nal2ab_pkg;

  localparam logic [4:0] TypeMask = 5'((1 << 5) - 1);
  localparam logic [4:0] TypeIdr = 5'd5;
  localparam logic [4:0] TypeSps = 5'd7;
  localparam logic [4:0] TypePps = 5'd8;
  localparam logic [7:0] EpbByte = 8'd3;
  localparam int unsigned HeadDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       nal_last;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       key_frame;
  } res_t;

  typedef enum logic [1:0] {
    OP_RAW,
    OP_CONV,
    OP_BODY
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic [2:0]                 cnt;
    logic [HeadDepth-1:0][7:0]  bytes;
    logic                       nal_end;
    logic                       frame_end;
    logic                       key;
  } cmd_t;

endpackage

FILE: sv/nal2ab_front.sv
`timescale 1ns / 1ps
// Front end: accepts NAL bytes, holds the NAL head and issues byte commands.
// Depends on nal2ab_pkg.
module nal2ab_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  nal2ab_pkg::in_t    in_i,
  output logic               cmd_push_o,
  output nal2ab_pkg::cmd_t   cmd_o
);
  import nal2ab_pkg::*;

  logic [2:0]      head_count_q, head_count_d;
  logic [2:0][7:0] held_q;
  logic            copy_q, copy_d;
  logic            key_q, key_d;
  logic [7:0]      b;
  logic [7:0]      hdr;
  logic [4:0]      hdr_type;
  logic            nl;
  logic            key_hit;
  logic            start_code;

  assign b = in_i.data_byte;
  assign nl = in_i.nal_last | in_i.frame_last;
  assign hdr = (head_count_q == 3'd0) ? b : held_q[0];
  assign hdr_type = hdr[4:0] & TypeMask;
  assign key_hit = hdr_type inside {TypeIdr, TypeSps, TypePps};
  assign start_code = (held_q[0] == 8'd0) && (held_q[1] == 8'd0) &&
                      (held_q[2] == 8'd0) && (b == 8'd1);

  always_comb begin
    cmd_o = '0;
    cmd_o.op = OP_RAW;
    cmd_o.bytes[0] = (head_count_q == 3'd0) ? b : held_q[0];
    cmd_o.bytes[1] = (head_count_q == 3'd1) ? b : held_q[1];
    cmd_o.bytes[2] = (head_count_q == 3'd2) ? b : held_q[2];
    cmd_o.bytes[3] = b;
    cmd_o.cnt = head_count_q + 3'd1;
    cmd_o.nal_end = nl;
    cmd_o.frame_end = in_i.frame_last;
    cmd_push_o = 1'b0;
    head_count_d = head_count_q;
    copy_d = copy_q;
    key_d = key_q;
    if (acc_i) begin
      if (head_count_q < 3'(HeadDepth)) begin
        head_count_d = head_count_q + 3'd1;
        if (head_count_q == 3'(HeadDepth - 1)) begin
          cmd_push_o = 1'b1;
          if (start_code) begin
            cmd_o.op = OP_RAW;
            copy_d = 1'b1;
          end else begin
            cmd_o.op = OP_CONV;
            copy_d = 1'b0;
            key_d = key_q | key_hit;
          end
        end else if (nl) begin
          cmd_push_o = 1'b1;
          cmd_o.op = OP_CONV;
          key_d = key_q | key_hit;
        end
      end else begin
        cmd_push_o = 1'b1;
        cmd_o.cnt = 3'd1;
        cmd_o.bytes[0] = b;
        cmd_o.op = copy_q ? OP_RAW : OP_BODY;
      end
      cmd_o.key = key_d;
      if (nl) begin
        head_count_d = 3'd0;
        copy_d = 1'b0;
      end
      if (in_i.frame_last) begin
        key_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_count_q <= 3'd0;
      copy_q <= 1'b0;
      key_q <= 1'b0;
    end else begin
      head_count_q <= head_count_d;
      copy_q <= copy_d;
      key_q <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && (head_count_q < 3'(HeadDepth - 1))) begin
      held_q[head_count_q[1:0]] <= b;
    end
  end

endmodule

FILE: sv/nal2ab_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the byte emitter.
// Depends on nal2ab_pkg.
module nal2ab_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  nal2ab_pkg::cmd_t  data_i,
  input  logic              pop_i,
  output nal2ab_pkg::cmd_t  data_o,
  output logic              full_o,
  output logic              valid_o
);
  import nal2ab_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/nal2ab_back.sv
`timescale 1ns / 1ps
// Back end: expands commands into Annex B bytes with emulation prevention.
// Depends on nal2ab_pkg.
module nal2ab_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  nal2ab_pkg::cmd_t  cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output nal2ab_pkg::res_t  res_o
);
  import nal2ab_pkg::*;

  logic [2:0] pre_q, pre_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] zrun_q, zrun_d;
  logic       out_valid_q;
  res_t       out_q;
  res_t       res_d;
  logic       advance;
  logic       in_prefix;
  logic       raw;
  logic       last;
  logic [7:0] cur;
  logic [1:0] last_idx;

  assign advance = cmd_valid_i && (!out_valid_q || pop_i);
  assign in_prefix = (cmd_i.op == OP_CONV) && (pre_q < 3'd4);
  assign cur = cmd_i.bytes[idx_q];
  assign raw = (cmd_i.op == OP_RAW) || ((cmd_i.op == OP_CONV) && (idx_q == 2'd0));
  assign last_idx = 2'(cmd_i.cnt - 3'd1);

  always_comb begin
    pre_d = pre_q;
    idx_d = idx_q;
    zrun_d = zrun_q;
    last = 1'b0;
    res_d = '0;
    if (in_prefix) begin
      res_d.out_byte = (pre_q == 3'd3) ? 8'd1 : 8'd0;
      pre_d = pre_q + 3'd1;
    end else if (!raw && (zrun_q == 2'd2) && (cur <= EpbByte)) begin
      res_d.out_byte = EpbByte;
      zrun_d = 2'd0;
    end else begin
      res_d.out_byte = cur;
      if (raw || (cur != 8'd0)) begin
        zrun_d = 2'd0;
      end else if (zrun_q != 2'd2) begin
        zrun_d = zrun_q + 2'd1;
      end
      if (idx_q == last_idx) begin
        last = 1'b1;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (last) begin
      pre_d = 3'd0;
      idx_d = 2'd0;
      if (cmd_i.nal_end) begin
        zrun_d = 2'd0;
      end
      res_d.run_last = 1'b1;
      res_d.frame_end = cmd_i.frame_end;
      res_d.key_frame = cmd_i.frame_end & cmd_i.key;
    end
  end

  assign cmd_pop_o = advance && last;
  assign empty_o = !out_valid_q;
  assign res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= 3'd0;
      idx_q <= 2'd0;
      zrun_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        pre_q <= pre_d;
        idx_q <= idx_d;
        zrun_q <= zrun_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

endmodule

FILE: sv/nal_to_annexb_emulation_prevention.sv
`timescale 1ns / 1ps
// NAL unit bytes in, Annex B byte stream with emulation prevention out.
// With the emitter idle, the command for an input beat is registered in the command queue, and
// its first result beat then in the emitter's output register. One input beat per cycle while the
// command queue has room; the emitter sends one output beat per cycle while its results are popped.
// Reset: asynchronous, active low; clears all control state and empties the queues.
module nal_to_annexb_emulation_prevention #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  nal2ab_pkg::in_t   in_data_i,
  output logic              empty,
  input  logic              pop,
  output nal2ab_pkg::res_t  out_data_o
);
  import nal2ab_pkg::*;

  logic acc;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign acc = push && !full;

  nal2ab_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_i       (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  nal2ab_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .valid_o (cmd_valid)
  );

  nal2ab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_data_o)
  );

endmodule

FILE: tb/sv/annexb_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the NAL to Annex B converter: predicts the output byte stream from the
// accepted input beats and compares every accepted result beat with the prediction.
// Depends on nal2ab_pkg.
module annexb_stream_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  nal2ab_pkg::in_t  in_data_i,
  input  logic             empty_i,
  input  logic             pop_i,
  input  nal2ab_pkg::res_t out_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_o
);
  import nal2ab_pkg::*;

  logic [2:0] held_cnt;
  logic [7:0] held [4];
  logic       copy_mode;
  logic [1:0] zeros;
  logic       key_pending;

  res_t annexb_expected[$];
  res_t burst[$];
  int   fail_count;
  int   results_seen;

  task automatic emit_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte = b;
    burst.push_back(r);
  endtask

  task automatic emit_escaped(input logic [7:0] b);
    if (zeros >= 2 && b <= EpbByte) begin
      emit_byte(EpbByte);
      zeros = 2'd0;
    end
    emit_byte(b);
    if (b == 8'd0) begin
      zeros = (zeros < 2) ? zeros + 2'd1 : 2'd2;
    end else begin
      zeros = 2'd0;
    end
  endtask

  task automatic emit_converted(input int count);
    logic [4:0] hdr_type;
    hdr_type = held[0][4:0] & TypeMask;
    if (hdr_type == TypeIdr || hdr_type == TypeSps || hdr_type == TypePps) begin
      key_pending = 1'b1;
    end
    emit_byte(8'd0);
    emit_byte(8'd0);
    emit_byte(8'd0);
    emit_byte(8'd1);
    emit_byte(held[0]);
    zeros = 2'd0;
    for (int i = 1; i < count && i < HeadDepth; i++) begin
      emit_escaped(held[i]);
    end
  endtask

  task automatic predict_annexb(input in_t beat);
    logic nal_end;
    res_t r;
    nal_end = beat.nal_last | beat.frame_last;
    burst.delete();
    if (held_cnt < HeadDepth) begin
      held[held_cnt[1:0]] = beat.data_byte;
      held_cnt = held_cnt + 3'd1;
      if (held_cnt == HeadDepth) begin
        if (held[0] == 8'd0 && held[1] == 8'd0 && held[2] == 8'd0 && held[3] == 8'd1) begin
          copy_mode = 1'b1;
          for (int i = 0; i < HeadDepth; i++) begin
            emit_byte(held[i]);
          end
        end else begin
          copy_mode = 1'b0;
          emit_converted(HeadDepth);
        end
      end else if (nal_end) begin
        emit_converted(int'(held_cnt));
      end
    end else if (copy_mode) begin
      emit_byte(beat.data_byte);
    end else begin
      emit_escaped(beat.data_byte);
    end
    if (burst.size() > 0) begin
      r = burst[burst.size() - 1];
      r.run_last = 1'b1;
      if (beat.frame_last) begin
        r.frame_end = 1'b1;
        r.key_frame = key_pending;
      end
      burst[burst.size() - 1] = r;
    end
    foreach (burst[i]) begin
      annexb_expected.push_back(burst[i]);
    end
    if (nal_end) begin
      held_cnt = 3'd0;
      copy_mode = 1'b0;
      zeros = 2'd0;
    end
    if (beat.frame_last) begin
      key_pending = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_beat;
    if (!rst_ni) begin
      held_cnt = 3'd0;
      copy_mode = 1'b0;
      zeros = 2'd0;
      key_pending = 1'b0;
      annexb_expected.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (push_i && !full_i) begin
        predict_annexb(in_data_i);
      end
      if (pop_i && !empty_i) begin
        results_seen++;
        if (annexb_expected.size() == 0) begin
          if (fail_count < 10) begin
            $display("Unexpected result beat: byte %02h last %b end %b key %b",
                     out_data_i.out_byte, out_data_i.run_last, out_data_i.frame_end,
                     out_data_i.key_frame);
          end
          fail_count++;
        end else begin
          exp_beat = annexb_expected.pop_front();
          if (out_data_i.out_byte !== exp_beat.out_byte ||
              out_data_i.run_last !== exp_beat.run_last ||
              out_data_i.frame_end !== exp_beat.frame_end ||
              out_data_i.key_frame !== exp_beat.key_frame) begin
            if (fail_count < 10) begin
              $display("Mismatch on result beat %0d: expected byte %02h last %b end %b key %b,",
                       results_seen, exp_beat.out_byte, exp_beat.run_last,
                       exp_beat.frame_end, exp_beat.key_frame);
              $display("  got byte %02h last %b end %b key %b",
                       out_data_i.out_byte, out_data_i.run_last, out_data_i.frame_end,
                       out_data_i.key_frame);
            end
            fail_count++;
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o <= annexb_expected.size();
    results_o <= results_seen;
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the NAL to Annex B converter testbench: clock, reset, input and output stimulus
// under changing idle patterns, and the final verdict. Depends on nal2ab_pkg,
// annexb_stream_checker and nal_to_annexb_emulation_prevention.
module tb;
  import nal2ab_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int PhaseBytes = 42;

  logic clk;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  res_t out_data;

  int fail_count;
  int pending;
  int results;
  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int nals_sent = 0;
  int cycle_count = 0;

  nal_to_annexb_emulation_prevention uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .full      (full),
    .in_data_i (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data)
  );

  annexb_stream_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push_i      (push),
    .full_i      (full),
    .in_data_i   (in_data),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run timed out after %0d cycles with %0d result beats outstanding.",
               cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic nal_last, input logic frame_last);
    in_t beat;
    beat.data_byte = b;
    beat.nal_last = nal_last;
    beat.frame_last = frame_last;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    bytes_sent++;
    if (nal_last || frame_last) begin
      nals_sent++;
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [7:0] body_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return 8'd0;
    end else if (pick < 7) begin
      return 8'($urandom_range(1, 3));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_nal();
    int kind;
    int len;
    bit ends_frame;
    logic [7:0] b;
    logic [4:0] hdr_type;
    logic last;
    kind = $urandom_range(9);
    if (kind <= 1) begin
      len = $urandom_range(4, 10);
    end else if ($urandom_range(3) == 0) begin
      len = $urandom_range(1, 3);
    end else begin
      len = $urandom_range(4, 12);
    end
    ends_frame = ($urandom_range(2) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind <= 1 && i < 3) begin
        b = 8'd0;
      end else if (kind <= 1 && i == 3) begin
        b = (kind == 0) ? 8'd1 : 8'($urandom_range(0, 3));
      end else if (i == 0) begin
        case ($urandom_range(4))
          0: hdr_type = TypeIdr;
          1: hdr_type = TypeSps;
          2: hdr_type = TypePps;
          default: hdr_type = 5'($urandom_range(31));
        endcase
        b = {3'($urandom_range(7)), hdr_type};
      end else begin
        b = body_byte();
      end
      last = (i == len - 1);
      if (last && kind == 2) begin
        send_byte(b, 1'b0, 1'b1);
      end else begin
        send_byte(b, last, last && ends_frame);
      end
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      send_random_nal();
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h65, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h67, 1'b0, 1'b1);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h68, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_drained();

    run_phase(32, 79);
    run_phase(79, 32);
    run_phase(0, 0);

    $display("Sent %0d NAL bytes in %0d NAL units and checked %0d Annex B output bytes,",
             bytes_sent, nals_sent, results);
    $display("covering copied, converted, short and escaped units under three idle patterns.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
